### sv/sc1a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sc1a_pkg;

    // Special scan codes (set 1)
    localparam logic [7:0] CODE_ACK        = 8'hFA;
    localparam logic [7:0] CODE_NUMLOCK    = 8'h45;
    localparam logic [7:0] CODE_NUMLOCK_UP = 8'hC5;
    localparam logic [7:0] CODE_LSHIFT     = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT     = 8'h36;
    localparam logic [7:0] CODE_LSHIFT_UP  = 8'hAA;
    localparam logic [7:0] CODE_RSHIFT_UP  = 8'hB6;
    localparam logic [7:0] CODE_THREE      = 8'h04;
    localparam int         BREAK_BIT       = 7;

    // Output byte constants
    localparam logic [7:0] POUND_LEAD  = 8'hC2;
    localparam logic [7:0] POUND_TRAIL = 8'hA3;
    localparam logic [7:0] CHAR_NL     = 8'h0A;

    // Run lengths and the byte counter
    localparam int IDX_W      = 4;
    localparam int POUND_LEN  = 2;
    localparam int RUN_LEN    = 14;
    localparam int PREFIX_LEN = 11;

    // Default depth of the command queue
    localparam int CMDQ_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        K_CHAR,
        K_POUND,
        K_RUN
    } t_kind;

    // One classified command handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;   // character for K_CHAR, scan code for K_RUN
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Unshifted map, zero for unmapped codes
    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'h02: c = "1";
            7'h03: c = "2";
            7'h04: c = "3";
            7'h05: c = "4";
            7'h06: c = "5";
            7'h07: c = "6";
            7'h08: c = "7";
            7'h09: c = "8";
            7'h0A: c = "9";
            7'h0B: c = "0";
            7'h10: c = "q";
            7'h11: c = "w";
            7'h12: c = "e";
            7'h13: c = "r";
            7'h14: c = "t";
            7'h15: c = "y";
            7'h16: c = "u";
            7'h17: c = "i";
            7'h18: c = "o";
            7'h19: c = "p";
            7'h1E: c = "a";
            7'h1F: c = "s";
            7'h20: c = "d";
            7'h21: c = "f";
            7'h22: c = "g";
            7'h23: c = "h";
            7'h24: c = "j";
            7'h25: c = "k";
            7'h26: c = "l";
            7'h2C: c = "z";
            7'h2D: c = "x";
            7'h2E: c = "c";
            7'h2F: c = "v";
            7'h30: c = "b";
            7'h31: c = "n";
            7'h32: c = "m";
            7'h33: c = ",";
            7'h34: c = ".";
            7'h35: c = "-";
            7'h1C: c = CHAR_NL;
            7'h39: c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Shifted map, zero for unmapped codes (shift-3 handled apart)
    function automatic logic [7:0] shift_char(input logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'h02: c = "!";
            7'h03: c = 8'h22;
            7'h05: c = "$";
            7'h06: c = "%";
            7'h07: c = "^";
            7'h08: c = "&";
            7'h09: c = "*";
            7'h0A: c = "(";
            7'h0B: c = ")";
            7'h10: c = "Q";
            7'h11: c = "W";
            7'h12: c = "E";
            7'h13: c = "R";
            7'h14: c = "T";
            7'h15: c = "Y";
            7'h16: c = "U";
            7'h17: c = "I";
            7'h18: c = "O";
            7'h19: c = "P";
            7'h1E: c = "A";
            7'h1F: c = "S";
            7'h20: c = "D";
            7'h21: c = "F";
            7'h22: c = "G";
            7'h23: c = "H";
            7'h24: c = "J";
            7'h25: c = "K";
            7'h26: c = "L";
            7'h2C: c = "Z";
            7'h2D: c = "X";
            7'h2E: c = "C";
            7'h2F: c = "V";
            7'h30: c = "B";
            7'h31: c = "N";
            7'h32: c = "M";
            7'h33: c = "<";
            7'h34: c = ">";
            7'h35: c = "~";
            7'h1C: c = CHAR_NL;
            7'h39: c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "KEYBOARD 0x"
    function automatic logic [7:0] prefix_char(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = "K";
            4'd1:  c = "E";
            4'd2:  c = "Y";
            4'd3:  c = "B";
            4'd4:  c = "O";
            4'd5:  c = "A";
            4'd6:  c = "R";
            4'd7:  c = "D";
            4'd8:  c = " ";
            4'd9:  c = "0";
            4'd10: c = "x";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/scancode_set1_to_ascii_unit.sv
// A code goes into the command queue, and its bytes then into the output register.
// Throughput: a code is taken every cycle while the command queue has room; the back end
// sends one byte per cycle while the output register is free, so a command yields 1
// (character), 2 (pound) or 14 (hex run) bytes, which sets the sustained rate.
// Reset (synchronous, active low): shift flag cleared, queue and output register emptied.
`timescale 1ns / 1ps
`default_nettype none

module scancode_set1_to_ascii_unit
    import sc1a_pkg::*;
#(
    parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output      logic       full,
    input  wire logic [7:0] i_scan_code,
    output      logic       empty,
    input  wire logic       pop,
    output      logic [7:0] o_char_byte,
    output      logic       o_last_of_run
);

    logic   accept;
    logic   cmd_valid;
    t_cmd   cmd;
    t_cmd   head;
    t_qstat qstat;
    logic   q_rd;
    logic   shift_held;

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    // Front: classification and shift flag
    sc1a_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_scan_code  (i_scan_code),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .o_shift_held (shift_held)
    );

    // Command queue between front and back
    sc1a_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_wdata (cmd),
        .i_rd    (q_rd),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // Back: byte expansion and output register
    sc1a_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_qstat       (qstat),
        .o_rd          (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_char_byte   (o_char_byte),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTH
    // Queue can never be full and empty at once
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("command queue full and empty together");

    // Shift make sets the flag
    a_shift_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_scan_code == CODE_LSHIFT || i_scan_code == CODE_RSHIFT))
        |=> shift_held)
        else $error("shift make did not set flag");

    // Shift break clears the flag
    a_shift_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_scan_code == CODE_LSHIFT_UP || i_scan_code == CODE_RSHIFT_UP))
        |=> !shift_held)
        else $error("shift break did not clear flag");

    // Back end only retires a command that exists
    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !qstat.empty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### sv/sc1a_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sc1a_front
    import sc1a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_scan_code,
    output      logic       o_cmd_valid,
    output      t_cmd       o_cmd,
    output      logic       o_shift_held
);

    logic       r_shift;
    logic       n_shift;
    logic [7:0] ch;

    // Classify one scan code
    always_comb begin
        n_shift     = r_shift;
        o_cmd_valid = 1'b0;
        o_cmd.kind  = K_CHAR;
        o_cmd.data  = i_scan_code;
        ch = r_shift ? shift_char(i_scan_code[6:0]) : plain_char(i_scan_code[6:0]);
        if (i_scan_code == CODE_ACK || i_scan_code == CODE_NUMLOCK
                || i_scan_code == CODE_NUMLOCK_UP) begin
            // ignored
        end else if (i_scan_code == CODE_LSHIFT || i_scan_code == CODE_RSHIFT) begin
            n_shift = 1'b1;
        end else if (i_scan_code == CODE_LSHIFT_UP || i_scan_code == CODE_RSHIFT_UP) begin
            n_shift = 1'b0;
        end else if (i_scan_code[BREAK_BIT]) begin
            // other break codes give nothing
        end else if (r_shift && i_scan_code == CODE_THREE) begin
            o_cmd_valid = 1'b1;
            o_cmd.kind  = K_POUND;
        end else if (ch != 8'h00) begin
            o_cmd_valid = 1'b1;
            o_cmd.kind  = K_CHAR;
            o_cmd.data  = ch;
        end else begin
            o_cmd_valid = 1'b1;
            o_cmd.kind  = K_RUN;
        end
        if (!i_accept) begin
            n_shift     = r_shift;
            o_cmd_valid = 1'b0;
        end
    end

    // Shift flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
        end else begin
            r_shift <= n_shift;
        end
    end

    assign o_shift_held = r_shift;

endmodule

`default_nettype wire

### sv/sc1a_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none

module sc1a_cmdq
    import sc1a_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_cmd   i_wdata,
    input  wire logic   i_rd,
    output      t_cmd   o_head,
    output      t_qstat o_qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_qstat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_wr = i_wr && !o_qstat.full;
    assign do_rd = i_rd && !o_qstat.empty;
    assign o_head = mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/sc1a_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sc1a_back
    import sc1a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_head,
    input  wire t_qstat     i_qstat,
    output      logic       o_rd,
    input  wire logic       i_pop,
    output      logic       o_empty,
    output      logic [7:0] o_char_byte,
    output      logic       o_last_of_run
);

    logic [IDX_W-1:0] r_idx;
    logic             r_ov;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             slot_free;
    logic             gen;
    logic [7:0]       g_byte;
    logic             g_last;

    // Byte for the queue head at the current position
    always_comb begin
        g_byte = 8'h00;
        g_last = 1'b0;
        case (i_head.kind)
            K_CHAR: begin
                g_byte = i_head.data;
                g_last = 1'b1;
            end
            K_POUND: begin
                g_byte = (r_idx == '0) ? POUND_LEAD : POUND_TRAIL;
                g_last = (r_idx == IDX_W'(POUND_LEN - 1));
            end
            K_RUN: begin
                if (r_idx < IDX_W'(PREFIX_LEN)) begin
                    g_byte = prefix_char(r_idx);
                end else if (r_idx == IDX_W'(PREFIX_LEN)) begin
                    g_byte = hex_char(i_head.data[7:4]);
                end else if (r_idx == IDX_W'(PREFIX_LEN + 1)) begin
                    g_byte = hex_char(i_head.data[3:0]);
                end else begin
                    g_byte = CHAR_NL;
                end
                g_last = (r_idx == IDX_W'(RUN_LEN - 1));
            end
            default: begin
                g_byte = 8'h00;
                g_last = 1'b1;
            end
        endcase
    end

    assign slot_free = !r_ov || i_pop;
    assign gen       = !i_qstat.empty && slot_free;
    assign o_rd      = gen && g_last;

    // Byte counter within the current command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (gen) begin
            r_idx <= g_last ? '0 : r_idx + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (slot_free) begin
            r_ov <= gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen) begin
            r_byte <= g_byte;
            r_last <= g_last;
        end
    end

    assign o_empty       = !r_ov;
    assign o_char_byte   = r_byte;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

### test/tb_scancode_set1_to_ascii_unit.sv
`timescale 1ns / 1ps

module tb_scancode_set1_to_ascii_unit;
    import sc1a_pkg::*;

    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_of_run;
    } t_char_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_scan_code = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_char_byte;
    logic       o_last_of_run;

    // stimulus and scoreboard state
    logic [7:0] pending_codes[$];
    t_char_beat expected_chars[$];
    logic       shift_down = 1'b0;
    logic       push_taken = 1'b0;
    bit         gaps_on = 1'b1;
    bit         hold_request = 1'b0;
    int         src_gap = 0;
    int         sink_stall = 0;
    int         mismatches = 0;

    scancode_set1_to_ascii_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_scan_code   (i_scan_code),
        .empty         (empty),
        .pop           (pop),
        .o_char_byte   (o_char_byte),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // UK key rows; returns 0 for keys with no single-byte character
    function automatic logic [7:0] key_char(input logic [6:0] key, input logic shifted);
        string      row;
        logic [7:0] c;
        c = 8'h00;
        if (key >= 7'h02 && key <= 7'h0B) begin
            row = shifted ? "!\"#$%^&*()" : "1234567890";
            c = row[key - 7'h02];
        end else if (key >= 7'h10 && key <= 7'h19) begin
            row = "qwertyuiop";
            c = row[key - 7'h10];
        end else if (key >= 7'h1E && key <= 7'h26) begin
            row = "asdfghjkl";
            c = row[key - 7'h1E];
        end else if (key >= 7'h2C && key <= 7'h35) begin
            row = shifted ? "zxcvbnm<>~" : "zxcvbnm,.-";
            c = row[key - 7'h2C];
        end else if (key == 7'h1C) begin
            c = CHAR_NL;
        end else if (key == 7'h39) begin
            c = " ";
        end
        // shifted letters are upper case
        if (shifted && c >= "a" && c <= "z") begin
            c = c - 8'h20;
        end
        return c;
    endfunction

    // advance the shift flag and queue the bytes that one code produces
    function automatic void predict_chars(input logic [7:0] code);
        string      prefix;
        string      hexset;
        logic [7:0] c;
        prefix = "KEYBOARD 0x";
        hexset = "0123456789ABCDEF";
        if (code == CODE_ACK || code == CODE_NUMLOCK || code == CODE_NUMLOCK_UP) begin
            return;
        end
        if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            shift_down = 1'b1;
            return;
        end
        if (code == CODE_LSHIFT_UP || code == CODE_RSHIFT_UP) begin
            shift_down = 1'b0;
            return;
        end
        if (code[BREAK_BIT]) begin
            return;
        end
        if (shift_down && code == CODE_THREE) begin
            expected_chars.push_back('{POUND_LEAD, 1'b0});
            expected_chars.push_back('{POUND_TRAIL, 1'b1});
            return;
        end
        c = key_char(code[6:0], shift_down);
        if (c != 8'h00) begin
            expected_chars.push_back('{c, 1'b1});
            return;
        end
        // unmapped make code: hex dump line
        for (int k = 0; k < PREFIX_LEN; k++) begin
            expected_chars.push_back('{prefix[k], 1'b0});
        end
        expected_chars.push_back('{hexset[code[7:4]], 1'b0});
        expected_chars.push_back('{hexset[code[3:0]], 1'b0});
        expected_chars.push_back('{CHAR_NL, 1'b1});
    endfunction

    // a make code for typing: mostly mapped keys, sometimes the three or an unmapped key
    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return CODE_THREE;
            1: return ($urandom_range(0, 1) != 0) ? 8'h1C : 8'h39;
            2: return {1'b0, 7'($urandom_range(0, 127))};
            3: return 8'($urandom_range(8'h02, 8'h0B));
            4: return 8'($urandom_range(8'h10, 8'h19));
            5: return 8'($urandom_range(8'h1E, 8'h26));
            default: return 8'($urandom_range(8'h2C, 8'h35));
        endcase
    endfunction

    // typing bursts with random content, plus some noise; ignored codes are not counted
    task automatic add_random_codes(input int n);
        int         cnt;
        int         keys;
        bit         shifted;
        logic [7:0] code;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 9) < 6) begin
                shifted = $urandom_range(0, 1);
                if (shifted) begin
                    pending_codes.push_back(($urandom_range(0, 1) != 0) ?
                                            CODE_LSHIFT : CODE_RSHIFT);
                end
                keys = $urandom_range(1, 4);
                repeat (keys) begin
                    pending_codes.push_back(pick_key());
                end
                cnt += keys;
                // sometimes the release gets lost and the next burst stays shifted
                if (shifted && $urandom_range(0, 4) != 0) begin
                    pending_codes.push_back(($urandom_range(0, 1) != 0) ?
                                            CODE_LSHIFT_UP : CODE_RSHIFT_UP);
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: code = 8'($urandom_range(0, 255));
                    1: code = {1'b1, 7'($urandom_range(0, 127))};
                    2: begin
                        case ($urandom_range(0, 2))
                            0: code = CODE_ACK;
                            1: code = CODE_NUMLOCK;
                            default: code = CODE_NUMLOCK_UP;
                        endcase
                    end
                    default: code = {1'b0, 7'($urandom_range(0, 127))};
                endcase
                pending_codes.push_back(code);
                if (!code[BREAK_BIT] && code != CODE_NUMLOCK) begin
                    cnt++;
                end
            end
        end
    endtask

    // sender pauses until everything sent has come back
    task automatic wait_drained();
        while (pending_codes.size() != 0 || push || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // input side: one code per beat, random gaps between codes
    always @(negedge i_clk) begin : drive_codes
        logic       push_n;
        logic [7:0] code_n;
        push_n = push;
        code_n = i_scan_code;
        if (i_rst_n) begin
            if (push && push_taken) begin
                push_n = 1'b0;
            end
            if (!push_n) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_codes.size() != 0) begin
                    code_n = pending_codes.pop_front();
                    push_n = 1'b1;
                    src_gap = gaps_on ? pick_gap() : 0;
                end
            end
        end
        push <= push_n;
        i_scan_code <= code_n;
    end

    // output side: random stalls, one long hold on request
    always @(negedge i_clk) begin : drive_pop
        logic pop_n;
        pop_n = 1'b0;
        if (hold_request) begin
            hold_request = 1'b0;
            sink_stall = LONG_HOLD;
        end
        if (sink_stall > 0) begin
            sink_stall--;
        end else begin
            pop_n = 1'b1;
            if (gaps_on) begin
                sink_stall = pick_gap();
            end
        end
        pop <= pop_n;
    end

    // predict on each accepted code, check each accepted byte
    always @(posedge i_clk) begin : check_chars
        t_char_beat want;
        push_taken = i_rst_n && push && !full;
        if (push_taken) begin
            predict_chars(i_scan_code);
        end
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got char %h last %b",
                         $time, o_char_byte, o_last_of_run);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (o_char_byte !== want.char_byte) begin
                    $display("%0t: char_byte mismatch: expected %h, got %h",
                             $time, want.char_byte, o_char_byte);
                    mismatches++;
                end
                if (o_last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run mismatch: expected %b, got %b",
                             $time, want.last_of_run, o_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, ignored codes, shift handling, pound, hex dump
        pending_codes = '{
            8'h00,            // unmapped, dumps as 00
            8'h7F,            // highest make code
            8'hFF,            // highest break code
            8'h80,            // lowest break code
            CODE_ACK, CODE_NUMLOCK, CODE_NUMLOCK_UP,
            8'h02,            // '1'
            8'h1C, 8'h39,     // enter, space unshifted
            CODE_THREE,       // plain '3'
            CODE_LSHIFT,
            CODE_THREE,       // pound sign
            8'h06,            // '%'
            8'h1C, 8'h39,     // enter, space shifted
            8'h33, 8'h10,     // '<', 'Q'
            8'h5A,            // unmapped under shift
            CODE_NUMLOCK,     // must not touch the shift flag
            8'h35,            // '~'
            CODE_LSHIFT_UP,
            8'h35,            // '-'
            CODE_RSHIFT, 8'h26, CODE_RSHIFT_UP,
            8'hA6             // plain break code
        };
        wait_drained();

        // receiver holds off while the sender keeps going
        hold_request = 1'b1;
        add_random_codes(20);
        wait_drained();

        // stretch with no idling on either side
        gaps_on = 1'b0;
        add_random_codes(15);
        wait_drained();

        gaps_on = 1'b1;
        add_random_codes(20);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
sv/sc1a_pkg.sv
sv/sc1a_front.sv
sv/sc1a_cmdq.sv
sv/sc1a_back.sv
sv/scancode_set1_to_ascii_unit.sv
test/tb_scancode_set1_to_ascii_unit.sv
